/* sv/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* sv/b64rd_pkg.sv */
// types and constants for the base64url record decoder
// no dependencies; used by every module of the block
package b64rd_pkg;

	// operation codes of a classified beat
	localparam logic [1:0] OP_CHAR = 2'd0;
	localparam logic [1:0] OP_BAD  = 2'd1;
	localparam logic [1:0] OP_END  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_RECORD      = 2'd0;
	localparam logic [1:0] KIND_END_OK      = 2'd1;
	localparam logic [1:0] KIND_END_BAD     = 2'd2;
	localparam logic [1:0] KIND_END_PARTIAL = 2'd3;

	localparam int RECORD_W     = 48;
	localparam int RECORD_BYTES = 6;
	localparam logic [2:0] LAST_BYTE = 3'd5;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	typedef struct packed {
		logic [1:0] op;
		logic [5:0] sixbit;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic valid;
		logic [5:0] value;
	} sixbit_t;

	// base64url alphabet lookup
	function automatic sixbit_t sixbit_lookup(input logic [7:0] c);
		sixbit_t r;
		r.valid = 1'b1;
		r.value = 6'd0;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r.value = 6'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r.value = 6'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 6'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2d) begin
			r.value = 6'd62;
		end else if (c == 8'h5f) begin
			r.value = 6'd63;
		end else begin
			r.valid = 1'b0;
		end
		return r;
	endfunction

endpackage

/* sv/b64rd_front.sv */
// front end: classifies each command beat into an operation
// depends on b64rd_pkg
module b64rd_front (
	input  logic              command,
	input  logic [7:0]        character,
	output b64rd_pkg::item_t  item
);

	b64rd_pkg::sixbit_t look;

	always_comb begin
		look = b64rd_pkg::sixbit_lookup(character);
		item.sixbit = look.value;
		if (command) begin
			item.op = b64rd_pkg::OP_END;
		end else if (look.valid) begin
			item.op = b64rd_pkg::OP_CHAR;
		end else begin
			item.op = b64rd_pkg::OP_BAD;
		end
	end

endmodule

/* sv/b64rd_queue.sv */
// short fifo of classified beats between front and back
// depends on b64rd_pkg
module b64rd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b64rd_pkg::item_t  push_item,
	output logic              full,
	input  logic              pop,
	output b64rd_pkg::head_t  head
);

	localparam int Q_CW = b64rd_pkg::Q_AW + 1;
	localparam logic [Q_CW-1:0] DEPTH_C = Q_CW'(b64rd_pkg::Q_DEPTH);

	b64rd_pkg::item_t            mem_q [b64rd_pkg::Q_DEPTH];
	logic [b64rd_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [b64rd_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [Q_CW-1:0]             count_q;

	assign full       = (count_q == DEPTH_C);
	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/b64rd_back.sv */
// back end: bit accumulator, record assembly and result register
// depends on b64rd_pkg
module b64rd_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  b64rd_pkg::head_t                  head,
	output logic                              pop,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [1:0]                        kind,
	output logic [b64rd_pkg::RECORD_W-1:0]    record
);

	localparam int REC_W = b64rd_pkg::RECORD_W - 8;

	logic [5:0]       acc_q;
	logic [2:0]       bcnt_q;
	logic [REC_W-1:0] rec_q;
	logic [2:0]       cnt_q;
	logic             err_q;
	logic             res_valid_q;
	logic [1:0]       kind_q;
	logic [b64rd_pkg::RECORD_W-1:0] record_q;

	logic [11:0] wide;
	logic [3:0]  sum;
	logic [3:0]  shamt;
	logic [11:0] rest;
	logic [7:0]  byte_v;
	logic        is_char;
	logic        byte_ready;
	logic        rec_done;
	logic        is_end;
	logic        emits;
	logic        out_free;
	logic [1:0]  end_kind;

	always_comb begin
		wide       = {acc_q, head.item.sixbit};
		sum        = {1'b0, bcnt_q} + 4'd6;
		shamt      = sum - 4'd8;
		byte_v     = 8'(wide >> shamt);
		rest       = wide & ((12'd1 << shamt) - 12'd1);
		is_char    = (head.item.op == b64rd_pkg::OP_CHAR) && !err_q;
		byte_ready = is_char && (sum >= 4'd8);
		rec_done   = byte_ready && (cnt_q == b64rd_pkg::LAST_BYTE);
		is_end     = (head.item.op == b64rd_pkg::OP_END);
		emits      = head.valid && (is_end || rec_done);
		out_free   = !res_valid_q || !res_stall;
		pop        = head.valid && (out_free || !emits);
		priority if (err_q) begin
			end_kind = b64rd_pkg::KIND_END_BAD;
		end else if (cnt_q != 3'd0) begin
			end_kind = b64rd_pkg::KIND_END_PARTIAL;
		end else begin
			end_kind = b64rd_pkg::KIND_END_OK;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			bcnt_q <= '0;
			rec_q  <= '0;
			cnt_q  <= '0;
			err_q  <= 1'b0;
		end else if (pop) begin
			unique case (head.item.op)
				b64rd_pkg::OP_END: begin
					acc_q  <= '0;
					bcnt_q <= '0;
					rec_q  <= '0;
					cnt_q  <= '0;
					err_q  <= 1'b0;
				end
				b64rd_pkg::OP_BAD: begin
					err_q <= 1'b1;
				end
				b64rd_pkg::OP_CHAR: begin
					if (!err_q) begin
						if (sum >= 4'd8) begin
							acc_q  <= rest[5:0];
							bcnt_q <= shamt[2:0];
							if (cnt_q == b64rd_pkg::LAST_BYTE) begin
								rec_q <= '0;
								cnt_q <= '0;
							end else begin
								rec_q <= {rec_q[REC_W-9:0], byte_v};
								cnt_q <= cnt_q + 3'd1;
							end
						end else begin
							acc_q  <= head.item.sixbit;
							bcnt_q <= sum[2:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= emits;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emits) begin
			if (is_end) begin
				kind_q   <= end_kind;
				record_q <= '0;
			end else begin
				kind_q   <= b64rd_pkg::KIND_RECORD;
				record_q <= {rec_q, byte_v};
			end
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign record    = record_q;

endmodule

/* sv/base64url_settings_record_decoder.sv */
// top level of the base64url record decoder
// depends on b64rd_pkg, b64rd_front, b64rd_queue, b64rd_back
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  cmd     | cmd_valid / cmd_stall | command, character
//  res     | res_valid / res_stall | kind, record
//
// one beat per cycle sustained while res_stall does not hold the back: the
// front classifies a character in the cycle it arrives, the back folds one
// queued beat per cycle into the accumulator and record buffer
// an accepted beat is registered in the queue, its result in the result register
// cmd_stall rises only while the two-entry queue is full; res_stall holds
// the result register and stops the back only for beats that yield a result
// arst_n clears the queue, all decode state and the result valid
module base64url_settings_record_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        command,
	input  logic [7:0]  character,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [47:0] record
);

	b64rd_pkg::item_t front_item;
	b64rd_pkg::head_t head;
	logic             q_full;
	logic             pop;
	logic             push;

	// classify the incoming character or end command
	b64rd_front u_front (
		.command   (command),
		.character (character),
		.item      (front_item)
	);

	// a beat is taken whenever the queue has room
	assign cmd_stall = q_full;
	assign push      = cmd_valid && !q_full;

	// decouples the front from a stalled result side
	b64rd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	// accumulator, record builder and output register
	b64rd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.record    (record)
	);

endmodule

/* sv/b64rd_checker.sv */
// port-level checks for the base64url record decoder, bound to the top level
// depends on b64rd_pkg and assert_macros.svh
`include "assert_macros.svh"

module b64rd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_stall,
	input logic        command,
	input logic [7:0]  character,
	input logic        res_valid,
	input logic        res_stall,
	input logic [1:0]  kind,
	input logic [47:0] record
);

	// a stalled result stays put
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(kind) && $stable(record))
	// end results carry an empty record
	`ASSERT_IMPLY(a_end_zero, clk, arst_n, res_valid && (kind != b64rd_pkg::KIND_RECORD), record == 48'd0)
	// right after reset nothing is pending and the input is open
	`ASSERT_IMPLY(a_reset_idle, clk, arst_n, !$past(arst_n), !res_valid && !cmd_stall)

endmodule

bind base64url_settings_record_decoder b64rd_checker u_b64rd_checker (.*);

/* dv/tb_base64url_settings_record_decoder.sv */
// self-checking testbench for base64url_settings_record_decoder: random and directed
// character streams, results predicted per accepted beat and checked in order
// depends on b64rd_pkg and the rtl of the block only
module tb_base64url_settings_record_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	// command field codes
	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam int RANDOM_BEATS = 600;
	// beats left in the stream at or below which nobody idles any more
	localparam int QUIET_TAIL   = 80;

	typedef struct packed {
		logic       cmd;
		logic [7:0] ch;
	} stream_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] record;
	} decoded_result_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic        command   = CMD_CHAR;
	logic [7:0]  character = 8'h00;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [1:0]  kind;
	logic [47:0] record;

	base64url_settings_record_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command),
		.character (character),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.kind      (kind),
		.record    (record)
	);

	// beats waiting to be sent and results waiting to come back
	stream_beat_t    char_stream[$];
	decoded_result_t pending_results[$];
	stream_beat_t    next_beat;
	decoded_result_t oldest_result;

	int total_beats;
	int beats_accepted;
	int mismatches;

	// idle bursts: remaining cycles and the current chance (percent) to start one
	int send_gap;
	int recv_gap;
	int send_idle_pct;
	int recv_idle_pct;
	int mix_cycles;

	// predicted decoder state
	logic [13:0] bit_acc;
	logic [3:0]  acc_bits;
	logic [47:0] rec_bytes;
	logic [2:0]  rec_byte_cnt;
	logic        bad_char_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// {valid, value} of a base64url character, valid low for anything else
	function automatic logic [6:0] b64url_value(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return {1'b1, 6'(c - 8'd65)};
		if (c >= "a" && c <= "z")
			return {1'b1, 6'(c - 8'd97 + 8'd26)};
		if (c >= "0" && c <= "9")
			return {1'b1, 6'(c - 8'd48 + 8'd52)};
		if (c == "-")
			return {1'b1, 6'd62};
		if (c == "_")
			return {1'b1, 6'd63};
		return 7'd0;
	endfunction

	// character that encodes a six-bit value, used to build stimulus
	function automatic logic [7:0] b64url_char(input int unsigned idx);
		if (idx < 26)
			return 8'(8'd65 + idx);
		if (idx < 52)
			return 8'(8'd97 + idx - 26);
		if (idx < 62)
			return 8'(8'd48 + idx - 52);
		if (idx == 62)
			return "-";
		return "_";
	endfunction

	function automatic logic [7:0] random_bad_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (b64url_value(c) != 7'd0)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic clear_decoder_state();
		bit_acc       = '0;
		acc_bits      = '0;
		rec_bytes     = '0;
		rec_byte_cnt  = '0;
		bad_char_seen = 1'b0;
	endtask

	// fold one accepted beat into the predicted state, queue any result it makes
	task automatic decode_beat(input logic cmd, input logic [7:0] ch);
		logic [6:0]      lookup;
		logic [7:0]      out_byte;
		decoded_result_t res;
		if (cmd == CMD_END) begin
			// end status: bad character wins over a partial record
			if (bad_char_seen)
				res.kind = b64rd_pkg::KIND_END_BAD;
			else if (rec_byte_cnt != 0)
				res.kind = b64rd_pkg::KIND_END_PARTIAL;
			else
				res.kind = b64rd_pkg::KIND_END_OK;
			res.record = '0;
			pending_results.push_back(res);
			clear_decoder_state();
		end else if (!bad_char_seen) begin
			lookup = b64url_value(ch);
			if (!lookup[6]) begin
				bad_char_seen = 1'b1;
			end else begin
				bit_acc  = {bit_acc[7:0], lookup[5:0]};
				acc_bits = acc_bits + 4'd6;
				if (acc_bits >= 4'd8) begin
					// oldest eight bits leave as one byte
					out_byte = 8'(bit_acc >> (acc_bits - 4'd8));
					acc_bits = acc_bits - 4'd8;
					bit_acc  = bit_acc & ((14'd1 << acc_bits) - 14'd1);
					rec_bytes    = {rec_bytes[39:0], out_byte};
					rec_byte_cnt = rec_byte_cnt + 3'd1;
					if (rec_byte_cnt == 3'd6) begin
						res.kind   = b64rd_pkg::KIND_RECORD;
						res.record = rec_bytes;
						pending_results.push_back(res);
						rec_bytes    = '0;
						rec_byte_cnt = '0;
					end
				end
			end
		end
	endtask

	task automatic push_char(input logic [7:0] ch);
		char_stream.push_back('{cmd: CMD_CHAR, ch: ch});
	endtask

	task automatic push_end(input logic [7:0] ch);
		char_stream.push_back('{cmd: CMD_END, ch: ch});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	// a run of n alphabet characters with random content
	task automatic push_random_text(input int n);
		for (int i = 0; i < n; i++)
			push_char(b64url_char($urandom_range(0, 63)));
	endtask

	task automatic build_stimulus();
		int target;
		int shape;
		int n;
		int bad_pos;
		// every alphabet boundary in one complete record
		push_text("AZaz09-_");
		push_end(8'h00);
		// end right after reset state, character field ignored
		push_end(8'hff);
		// one byte only: partial record at end
		push_text("AB");
		push_end(8'h00);
		// six leftover bits are dropped, status stays ok
		push_char("A");
		push_end(8'h00);
		// padding character is bad, later characters ignored
		push_char("=");
		push_text("AA");
		push_end(8'h00);
		// byte extremes are both bad
		push_char(8'h00);
		push_end(8'h00);
		push_char(8'hff);
		push_end(8'h5f);

		target = char_stream.size() + RANDOM_BEATS;
		while (char_stream.size() < target) begin
			shape = $urandom_range(0, 99);
			if (shape < 55) begin
				// whole records
				push_random_text(8 * $urandom_range(1, 3));
			end else if (shape < 78) begin
				// any length: partial records and leftover bits
				push_random_text($urandom_range(0, 30));
			end else if (shape < 92) begin
				// broken sequence: one bad character somewhere inside
				n = $urandom_range(1, 20);
				bad_pos = $urandom_range(0, n - 1);
				for (int i = 0; i < n; i++) begin
					if (i == bad_pos)
						push_char(random_bad_char());
					else
						push_char(b64url_char($urandom_range(0, 63)));
				end
			end else begin
				// noise: raw bytes
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					push_char(8'($urandom_range(0, 255)));
			end
			// most sequences close with an end beat, the rest run on into the next
			if ($urandom_range(0, 99) < 80)
				push_end(8'($urandom_range(0, 255)));
		end
		push_end(8'h00);
	endtask

	// idling mix is redrawn at regular points counted by mix_cycles, including stretches with none
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_cycles    <= 0;
			send_idle_pct <= 0;
			recv_idle_pct <= 0;
		end else begin
			mix_cycles <= mix_cycles + 1;
			if (mix_cycles % 64 == 0) begin
				case ($urandom_range(0, 3))
					0: send_idle_pct <= 0;
					1: send_idle_pct <= 10;
					2: send_idle_pct <= 30;
					default: send_idle_pct <= 60;
				endcase
				case ($urandom_range(0, 3))
					0: recv_idle_pct <= 0;
					1: recv_idle_pct <= 10;
					2: recv_idle_pct <= 30;
					default: recv_idle_pct <= 60;
				endcase
			end
		end
	end

	// driver: predicts each accepted beat, then presents the next one or an idle burst
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			command   <= CMD_CHAR;
			character <= 8'h00;
			send_gap  <= 0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				decode_beat(command, character);
				beats_accepted = beats_accepted + 1;
			end
			// a stalled beat holds its payload and valid
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap != 0) begin
					send_gap  <= send_gap - 1;
					cmd_valid <= 1'b0;
				end else if (char_stream.size() > QUIET_TAIL &&
						$urandom_range(0, 99) < send_idle_pct) begin
					// idle burst of random length, this cycle included
					send_gap  <= $urandom_range(0, 6);
					cmd_valid <= 1'b0;
				end else if (char_stream.size() != 0) begin
					next_beat = char_stream.pop_front();
					cmd_valid <= 1'b1;
					command   <= next_beat.cmd;
					character <= next_beat.ch;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			recv_gap  <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: kind %0d record %h", kind, record);
					mismatches = mismatches + 1;
				end else begin
					oldest_result = pending_results.pop_front();
					if (kind !== oldest_result.kind) begin
						$error("kind: expected %0d, actual %0d", oldest_result.kind, kind);
						mismatches = mismatches + 1;
					end
					if (record !== oldest_result.record) begin
						$error("record: expected %h, actual %h",
							oldest_result.record, record);
						mismatches = mismatches + 1;
					end
				end
			end
			// receiver stalls come in bursts too, none near the end
			if (recv_gap != 0) begin
				recv_gap  <= recv_gap - 1;
				res_stall <= 1'b1;
			end else if (char_stream.size() > QUIET_TAIL &&
					$urandom_range(0, 99) < recv_idle_pct) begin
				recv_gap  <= $urandom_range(0, 6);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		beats_accepted = 0;
		mismatches     = 0;
		clear_decoder_state();
		build_stimulus();
		total_beats = char_stream.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_accepted < total_beats)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// wait on so a stray late result is still seen
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
